// File: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block: configuration
// register indexes and the width of the register index.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Configuration register index width and register map
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

endpackage

`default_nettype wire

// File: hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial shift-and-add modular multiplier: result = (a * b) mod n for
// a, b < n. Scans b from its top bit down, one bit per cycle, keeping the
// accumulator below n with a compare-and-subtract after the doubling and
// after the add. With a = 1 it reduces an arbitrary b modulo n.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [MOD_BITS-1:0] a,
    input  wire logic [MOD_BITS-1:0] b,
    input  wire logic [MOD_BITS-1:0] n,
    output logic                     done,
    output logic [MOD_BITS-1:0]      result
);

    localparam int CW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] n_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] acc_next;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   n_ext;
    logic [MOD_BITS:0]   red1;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   red2;

    // One step: double, reduce, conditionally add a, reduce
    always_comb
    begin
        n_ext = {1'b0, n_reg};
        dbl   = {acc_reg, 1'b0};
        red1  = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum   = b_reg[MOD_BITS-1] ? (red1 + {1'b0, a_reg}) : red1;
        red2  = (sum >= n_ext) ? (sum - n_ext) : sum;
        acc_next = red2[MOD_BITS-1:0];
    end

    // Operand registers, bit counter and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                n_reg    <= n;
                acc_reg  <= '0;
                cnt_reg  <= CW'(MOD_BITS - 1);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                acc_reg  <= acc_next;
                b_reg    <= {b_reg[MOD_BITS-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                // last bit: drop busy and pulse done
                busy_reg <= (cnt_reg != '0);
                done_reg <= (cnt_reg == '0);
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// File: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary modular exponentiation: cipher = message^exponent
// mod modulus, one cipher word per message word.
// ----------------------------------------------------------------------------
// One item is in flight at a time; s_tready is high only while idle. All
// arithmetic goes through a single bit-serial modular multiplier. An item
// costs one product to reduce the message, one squaring per exponent bit
// and one further product per set exponent bit. A modulus below 2 returns
// 0 without using the multiplier. The result sits in an output register, so
// the next message may be taken while it waits. Configuration writes belong
// to idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 21,
    parameter int MOD_BITS = 31
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input stream: tdata = message [MOD_BITS-1:0], zero padding above
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((MOD_BITS+7)/8)*8-1:0]        s_tdata,
    // Output stream: tdata = cipher [MOD_BITS-1:0], zero padding above
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((MOD_BITS+7)/8)*8-1:0]             m_tdata,
    // Configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
    input  wire logic [((MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS)-1:0] cfg_wdata
);

    localparam int DW = ((MOD_BITS + 7) / 8) * 8;
    localparam int JW = $clog2(EXP_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [MOD_BITS-1:0] modulus_reg;
    logic [EXP_BITS-1:0] exponent_reg;
    logic [MOD_BITS-1:0] n_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic [JW-1:0]       j_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] sq_reg;
    logic                mm_start_reg;
    logic [MOD_BITS-1:0] mm_a_reg;
    logic [MOD_BITS-1:0] mm_b_reg;
    logic                m_tvalid_reg;
    logic [MOD_BITS-1:0] cipher_reg;

    logic                mm_done;
    logic [MOD_BITS-1:0] mm_result;
    logic                in_xfer;
    logic                mod_small;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_BITS'(2);
            exponent_reg <= EXP_BITS'(65537);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:  modulus_reg  <= cfg_wdata[MOD_BITS-1:0];
                REG_EXPONENT: exponent_reg <= cfg_wdata[EXP_BITS-1:0];
                default:      ;
            endcase
        end
    end

    assign in_xfer   = s_tvalid && s_tready;
    assign mod_small = (modulus_reg[MOD_BITS-1:1] == '0);

    // Shared modular multiplier
    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start_reg),
        .a      (mm_a_reg),
        .b      (mm_b_reg),
        .n      (n_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    // Sequencer: reduce, then square-and-multiply over the exponent bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mm_start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
        end
        else
        begin
            // Output transfer frees the register unless it is reloaded now
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        n_reg   <= modulus_reg;
                        e_reg   <= exponent_reg;
                        j_reg   <= '0;
                        if (mod_small)
                        begin
                            acc_reg      <= '0;
                            mm_start_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                        else
                        begin
                            // message mod n as 1 * message mod n
                            acc_reg      <= MOD_BITS'(1);
                            mm_a_reg     <= MOD_BITS'(1);
                            mm_b_reg     <= s_tdata[MOD_BITS-1:0];
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_REDUCE;
                        end
                    end
                    else
                    begin
                        mm_start_reg <= 1'b0;
                    end
                end

                ST_REDUCE:
                begin
                    mm_start_reg <= 1'b0;
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        state_reg <= ST_STEP;
                    end
                end

                ST_STEP:
                begin
                    if (j_reg == JW'(EXP_BITS))
                    begin
                        mm_start_reg <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                    else if (e_reg[0])
                    begin
                        mm_a_reg     <= acc_reg;
                        mm_b_reg     <= sq_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_MUL;
                    end
                    else
                    begin
                        mm_a_reg     <= sq_reg;
                        mm_b_reg     <= sq_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_SQR;
                    end
                end

                ST_MUL:
                begin
                    if (mm_done)
                    begin
                        acc_reg      <= mm_result;
                        mm_a_reg     <= sq_reg;
                        mm_b_reg     <= sq_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_SQR;
                    end
                    else
                    begin
                        mm_start_reg <= 1'b0;
                    end
                end

                ST_SQR:
                begin
                    mm_start_reg <= 1'b0;
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        e_reg     <= e_reg >> 1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_STEP;
                    end
                end

                ST_DONE:
                begin
                    mm_start_reg <= 1'b0;
                    // Load the output register once it is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        cipher_reg   <= acc_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    mm_start_reg <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(cipher_reg);

endmodule

`default_nettype wire

// File: bench/tb_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Stream-level check of the modular exponentiation block. Message words go
// in, and every cipher word that comes out is compared against a predicted
// value. The expected values come from an independent square-and-multiply
// model kept in a scoreboard. The run has a short directed part (field
// extremes, exponent zero, modulus one and zero, even exponents) and then
// random phases with different moduli and exponents, random idling on both
// sides, one phase with no idling, and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_modular_exponentiation;

    import mexp_pkg::*;

    localparam int EXP_W = 21;
    localparam int MOD_W = 31;
    localparam int DATA_W = ((MOD_W + 7) / 8) * 8;
    localparam int CFG_W = (MOD_W > EXP_W) ? MOD_W : EXP_W;

    localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
    localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int HOLD_CYCLES = 5000;
    localparam int IDLE_PERCENT = 26;
    localparam int TAIL_CYCLES = 1500;
    localparam longint CYCLE_LIMIT = 6000000;

    // ------------------------------------------------------------------------
    // Scoreboard: register copies, cipher prediction and checking
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        logic [MOD_W-1:0] modulus_copy;
        logic [EXP_W-1:0] exponent_copy;
        logic [MOD_W-1:0] expected_ciphers[$];
        int unsigned      checked;
        int unsigned      failures;

        function new();
            modulus_copy  = 2;
            exponent_copy = 65537;
            checked       = 0;
            failures      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_MODULUS)
                modulus_copy = value[MOD_W-1:0];
            else if (idx == REG_EXPONENT)
                exponent_copy = value[EXP_W-1:0];
        endfunction

        // Right-to-left square-and-multiply; products stay below 2^62
        function logic [MOD_W-1:0] raise_mod(logic [MOD_W-1:0] message);
            longint unsigned n;
            longint unsigned acc;
            longint unsigned sq;
            n = modulus_copy;
            if (n < 2)
                return '0;
            acc = 1;
            sq  = message % n;
            for (int j = 0; j < EXP_W; j++)
            begin
                if (exponent_copy[j])
                    acc = (acc * sq) % n;
                sq = (sq * sq) % n;
            end
            return acc[MOD_W-1:0];
        endfunction

        function void note_message(logic [MOD_W-1:0] message);
            expected_ciphers.push_back(raise_mod(message));
        endfunction

        function void check_cipher(logic [MOD_W-1:0] cipher);
            logic [MOD_W-1:0] want;
            if (expected_ciphers.size() == 0)
            begin
                $error("cipher transfer with nothing expected: actual %0d", cipher);
                failures++;
                return;
            end
            want = expected_ciphers.pop_front();
            checked++;
            if (cipher !== want)
            begin
                $error("cipher mismatch: expected %0d, actual %0d", want, cipher);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    cipher_scoreboard sb;

    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          hold_request    = 1'b0;
    int unsigned messages_sent   = 0;
    int unsigned settings_used   = 0;
    int unsigned holds_done      = 0;
    longint      cycle_count     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    modular_exponentiation #(
        .EXP_BITS (EXP_W),
        .MOD_BITS (MOD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // message [30:0], zero padding above
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // cipher [30:0], zero padding above
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Check every cipher transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_cipher(m_tdata[MOD_W-1:0]);
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("modular_exponentiation verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one message, keep tvalid high afterwards until told otherwise
    task automatic send_message(logic [MOD_W-1:0] message);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 99) < IDLE_PERCENT)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1500)
                                               : $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(message);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_message(message);
        messages_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Wait for every outstanding cipher, then let the block settle
    task automatic wait_drained();
        while (sb.expected_ciphers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes happen only once the block is idle; upper exponent bits are junk
    task automatic configure(logic [MOD_W-1:0] modulus, logic [EXP_W-1:0] exponent,
                             logic [CFG_W-EXP_W-1:0] junk);
        wait_drained();
        write_reg(REG_MODULUS, CFG_W'(modulus));
        write_reg(REG_EXPONENT, {junk, exponent});
        settings_used++;
    endtask

    // Random message biased towards values around the modulus
    function automatic logic [MOD_W-1:0] pick_message(logic [MOD_W-1:0] modulus);
        case ($urandom_range(0, 9))
            0: return MOD_W'($urandom_range(0, 1));
            1: return modulus - 1'b1;
            2: return modulus;
            3, 4: return MOD_W'($urandom_range(0, modulus - 1));
            default: return MOD_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [MOD_W-1:0] modulus;
        logic [EXP_W-1:0] exponent;

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: modulus 2, exponent 65537
        settings_used++;
        send_message('0);
        send_message(1);
        send_message(MOD_MAX);
        send_message(3);
        end_burst();

        // Largest modulus with an all-ones exponent
        configure(MOD_MAX, EXP_MAX, '0);
        send_message('0);
        send_message(1);
        send_message(2);
        send_message(MOD_MAX - 1'b1);
        send_message(MOD_MAX);
        send_message(31'h5555_5555);
        end_burst();

        // Exponent zero gives one
        configure(MOD_MAX, '0, '1);
        send_message('0);
        send_message(12345);
        send_message(MOD_MAX);
        end_burst();

        // Exponent one: plain reduction
        configure(1000003, 1, '0);
        send_message(MOD_MAX);
        send_message(999999);
        send_message(1000003);
        end_burst();

        // Modulus one, then zero: cipher is always zero
        configure(1, 65537, '0);
        send_message(MOD_MAX);
        send_message(5);
        end_burst();
        configure('0, EXP_MAX, '0);
        send_message(MOD_MAX);
        send_message(7);
        end_burst();

        // Even exponent: bit 0 clear must not fold the message in
        configure(MOD_MAX, 2, '0);
        send_message(7);
        send_message(MOD_MAX - 1'b1);
        end_burst();

        // Random phases
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: modulus = MOD_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                1: modulus = MOD_W'($urandom_range(2, 300));
                2: modulus = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
                default: modulus = MOD_W'($urandom_range(2, 65535));
            endcase
            case (p % 3)
                0: exponent = EXP_W'($urandom);
                1: exponent = EXP_W'($urandom_range(0, 63));
                default: exponent = EXP_W'($urandom_range(32'h10_0000, 32'h1F_FFFF));
            endcase
            configure(modulus, exponent, (CFG_W-EXP_W)'($urandom));

            // One stretch without any idling, one long output hold-off
            sender_steady   = (p == 2) || (p == 5);
            receiver_steady = (p == 2);
            if (p == 5)
                hold_request = 1'b1;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_message(pick_message(modulus));
            end_burst();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.expected_ciphers.size() != 0)
        begin
            $error("%0d cipher(s) never arrived", sb.expected_ciphers.size());
            sb.failures++;
        end

        $display("Run: %0d messages over %0d register settings, %0d ciphers compared.",
                 messages_sent, settings_used, sb.checked);
        $display("Included %0d long output hold-off(s) and a stretch without idling.",
                 holds_done);
        if (sb.failures == 0)
            $display("modular_exponentiation verification clean");
        else
            $display("modular_exponentiation verification failed");
        $finish;
    end

endmodule
